// ----- src/ifl_pkg.sv -----
// ----------------------------------------------------------------------------
// ifl_pkg
// Shared types, constants and the ring_next helper of the index free-list ring.
// ----------------------------------------------------------------------------
package ifl_pkg;

  localparam int DEPTH  = 64;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = 6;
  localparam int FREE_W = 7;
  localparam int REQ_W  = 2;

  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REINIT  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } ifl_state_t;

  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             clear;
  } ifl_mem_req_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ----- src/ifl_ram.sv -----
// ----------------------------------------------------------------------------
// ifl_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module ifl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/ifl_core.sv -----
// ----------------------------------------------------------------------------
// ifl_core
// Pointer, flag and count state of the free-list ring, the request sequencer
// and the result register.
// ----------------------------------------------------------------------------
module ifl_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ifl_pkg::REQ_W-1:0]   req_type,
  input  logic [ifl_pkg::IDX_W-1:0]   released_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ifl_pkg::IDX_W-1:0]   granted_index,
  output logic                        was_empty,
  output logic                        overwrote_oldest,
  output logic [ifl_pkg::FREE_W-1:0]  free_count,
  output ifl_pkg::ifl_mem_req_t       mem_req,
  input  logic [ifl_pkg::IDX_W-1:0]   slot_value
);
  import ifl_pkg::*;

  ifl_state_t       state, state_next;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic             full, full_next;
  logic [CNT_W-1:0] total, total_next;
  logic             out_valid_next;
  logic [IDX_W-1:0] granted, granted_next;
  logic             empty_flag, empty_flag_next;
  logic             ovw_flag, ovw_flag_next;
  logic [CNT_W-1:0] count_out, count_out_next;
  logic             accept;
  logic             ptr_eq;

  assign in_ready = (state == ST_IDLE) && !out_valid;
  assign accept   = in_valid && in_ready;
  assign ptr_eq   = (head == tail);

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    full_next       = full;
    total_next      = total;
    out_valid_next  = out_valid && !out_ready;
    granted_next    = granted;
    empty_flag_next = empty_flag;
    ovw_flag_next   = ovw_flag;
    count_out_next  = count_out;
    mem_req         = '0;
    mem_req.wr_addr = head;
    mem_req.wr_data = released_index;
    mem_req.rd_addr = tail;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          granted_next    = '0;
          empty_flag_next = 1'b0;
          ovw_flag_next   = 1'b0;
          count_out_next  = total;
          out_valid_next  = 1'b1;
          unique case (req_type)
            REQ_RELEASE: begin
              mem_req.wr_en = 1'b1;
              if (ptr_eq && full) begin
                tail_next     = ring_next(tail);
                ovw_flag_next = 1'b1;
              end else if (ring_next(head) == tail) begin
                full_next = 1'b1;
              end
              head_next = ring_next(head);
              if (total < CNT_W'(DEPTH)) begin
                total_next = total + 1'b1;
              end
              count_out_next = total_next;
            end
            REQ_ALLOC: begin
              if (ptr_eq && !full) begin
                empty_flag_next = 1'b1;
              end else begin
                if (ptr_eq) begin
                  full_next = 1'b0;
                end
                mem_req.rd_en = 1'b1;
                tail_next     = ring_next(tail);
                if (total != '0) begin
                  total_next = total - 1'b1;
                end
                count_out_next = total_next;
                out_valid_next = 1'b0;
                state_next     = ST_READ;
              end
            end
            REQ_REINIT: begin
              mem_req.clear  = 1'b1;
              head_next      = '0;
              tail_next      = '0;
              full_next      = 1'b1;
              total_next     = CNT_W'(DEPTH);
              count_out_next = CNT_W'(DEPTH);
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        granted_next   = slot_value;
        out_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      full      <= 1'b1;
      total     <= CNT_W'(DEPTH);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      full      <= full_next;
      total     <= total_next;
      out_valid <= out_valid_next;
    end
    granted    <= granted_next;
    empty_flag <= empty_flag_next;
    ovw_flag   <= ovw_flag_next;
    count_out  <= count_out_next;
  end

  assign granted_index    = granted;
  assign was_empty        = empty_flag;
  assign overwrote_oldest = ovw_flag;
  assign free_count       = FREE_W'(count_out);

endmodule

// ----- src/index_free_list_ring.sv -----
// ----------------------------------------------------------------------------
// index_free_list_ring
// Free-list allocator that keeps free slot indices in a circular queue.
// Release, reinitialize and unused requests, and an allocate that finds the
// queue empty, give their result in the cycle after the item is accepted; an
// allocate that pops an index first goes through the read state for the
// registered read of the slot RAM. One item is in flight at a time: no new
// item is taken until the result of the last one has been handed over.
// Reset and a reinitialize request clear the per-slot written bits at once,
// so every slot reads back its own index until it is written; no sweep is run.
// ----------------------------------------------------------------------------
module index_free_list_ring (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ifl_pkg::REQ_W-1:0]   req_type,
  input  logic [ifl_pkg::IDX_W-1:0]   released_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ifl_pkg::IDX_W-1:0]   granted_index,
  output logic                        was_empty,
  output logic                        overwrote_oldest,
  output logic [ifl_pkg::FREE_W-1:0]  free_count
);
  import ifl_pkg::*;

  ifl_mem_req_t     mem_req;
  logic [IDX_W-1:0] mem_data;
  logic [IDX_W-1:0] slot_value;
  logic [DEPTH-1:0] slot_written;
  logic             rd_written;
  logic [PTR_W-1:0] rd_addr;

  ifl_core u_core (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .req_type         (req_type),
    .released_index   (released_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .granted_index    (granted_index),
    .was_empty        (was_empty),
    .overwrote_oldest (overwrote_oldest),
    .free_count       (free_count),
    .mem_req          (mem_req),
    .slot_value       (slot_value)
  );

  ifl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (mem_data)
  );

  always_ff @(posedge clk) begin
    if (rst || mem_req.clear) begin
      slot_written <= '0;
    end else if (mem_req.wr_en) begin
      slot_written[mem_req.wr_addr] <= 1'b1;
    end
    if (mem_req.rd_en) begin
      rd_written <= slot_written[mem_req.rd_addr];
      rd_addr    <= mem_req.rd_addr;
    end
  end

  assign slot_value = rd_written ? mem_data : IDX_W'(rd_addr);

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_mem_excl: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.wr_en && (mem_req.clear || mem_req.rd_en)))
    else $error("slot RAM write overlaps a read or clear");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && was_empty) |-> (granted_index == '0 && free_count == '0))
    else $error("empty result carries an index or a count");

  a_overwrite_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overwrote_oldest) |-> (free_count == FREE_W'(DEPTH) && !was_empty))
    else $error("overwrite reported on a queue that was not full");

endmodule
